[rtl/core/ple_pkg.sv]
// Shared types and codes for the positional list engine.
// No dependencies; used by the top level by scoped names.
package ple_pkg;

  typedef enum logic [3:0] {
    REQ_PUSH_FRONT = 4'd0,
    REQ_PUSH_BACK  = 4'd1,
    REQ_INSERT     = 4'd2,
    REQ_ERASE      = 4'd3,
    REQ_FILL       = 4'd4,
    REQ_SWAP       = 4'd5,
    REQ_READ       = 4'd6,
    REQ_FRONT      = 4'd7,
    REQ_BACK       = 4'd8,
    REQ_CLEAR      = 4'd9
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BOUND = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SH_UP,
    S_UP_WR,
    S_SH_DN,
    S_DN_WR,
    S_FILL,
    S_SW_A,
    S_SW_B,
    S_SW_WB,
    S_RD_CAP,
    S_FIN
  } state_t;

endpackage

[rtl/core/positional_list_engine.sv]
// Positional list engine: fixed-capacity ordered list with 1-based positions.
// Push back, clear, ignored codes and rejects go straight to the result; read/front/back
// capture one entry; swap reads both entries, then writes them back; a fill writes N slots;
// push front, insert and erase move k entries one at a time. One request in flight; the next
// is taken once a result enters the output register, later while a held result blocks it.
// Reset (rst_n low, synchronous) empties the list and the output; RAM contents are not swept.
module positional_list_engine #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32,
  localparam int CNT_W = $clog2(CAPACITY + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  // request channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         in_req_type,
  input  logic [6:0]         in_pos_a,
  input  logic [6:0]         in_pos_b,
  input  logic signed [31:0] in_value,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_read_value,
  output logic [1:0]         out_status,
  output logic [CNT_W-1:0]   out_count,
  output logic               out_is_empty
);

  // Address width of the entry store, and a compare width that holds both
  // the 7-bit positions and the count plus one.
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int PW = ((CNT_W > 7) ? CNT_W : 7) + 1;

  // Sequencer state and the shared pointer/limit pair that every walk uses.
  ple_pkg::state_t  state_r,  state_nxt;
  logic [CNT_W-1:0] cnt_r,    cnt_nxt;
  logic [CNT_W-1:0] ptr_r,    ptr_nxt;
  logic [CNT_W-1:0] end_r,    end_nxt;
  logic [DATA_WIDTH-1:0] val_r,   val_nxt;
  logic [DATA_WIDTH-1:0] tmp_r,   tmp_nxt;
  logic [DATA_WIDTH-1:0] rdval_r, rdval_nxt;
  ple_pkg::status_t status_r, status_nxt;

  // Output register: holds a finished result while the sink stalls.
  logic               out_valid_r, out_valid_nxt;
  logic [31:0]        out_rv_r,    out_rv_nxt;
  logic [1:0]         out_st_r,    out_st_nxt;
  logic [CNT_W-1:0]   out_cnt_r,   out_cnt_nxt;
  logic               out_emp_r,   out_emp_nxt;

  // Entry store ports.
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;

  // Operand widening and range checks on the incoming beat.
  logic [63:0]           val_ext;
  logic [DATA_WIDTH-1:0] val_in;
  logic [63:0]           rd_ext;
  logic [PW-1:0]         a_w, b_w, c_w, cap_w;
  logic [PW-1:0]         a_dec, b_dec;
  logic                  a_ok, b_ok, not_full;

  assign val_ext  = {{32{in_value[31]}}, in_value};
  assign val_in   = val_ext[DATA_WIDTH-1:0];
  assign rd_ext   = 64'(rdval_r);
  assign a_w      = PW'(in_pos_a);
  assign b_w      = PW'(in_pos_b);
  assign c_w      = PW'(cnt_r);
  assign cap_w    = PW'(CAPACITY);
  assign a_dec    = a_w - PW'(1);
  assign b_dec    = b_w - PW'(1);
  assign a_ok     = (a_w != '0) && (a_w <= c_w);
  assign b_ok     = (b_w != '0) && (b_w <= c_w);
  assign not_full = (c_w < cap_w);

  assign in_stall = (state_r != ple_pkg::S_IDLE);

  ple_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ple_pkg::S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r     <= ptr_nxt;
    end_r     <= end_nxt;
    val_r     <= val_nxt;
    tmp_r     <= tmp_nxt;
    rdval_r   <= rdval_nxt;
    status_r  <= status_nxt;
    out_rv_r  <= out_rv_nxt;
    out_st_r  <= out_st_nxt;
    out_cnt_r <= out_cnt_nxt;
    out_emp_r <= out_emp_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ptr_nxt       = ptr_r;
    end_nxt       = end_r;
    val_nxt       = val_r;
    tmp_nxt       = tmp_r;
    rdval_nxt     = rdval_r;
    status_nxt    = status_r;
    ram_we        = 1'b0;
    ram_waddr     = ptr_r[AW-1:0];
    ram_wdata     = val_r;
    ram_raddr     = ptr_r[AW-1:0];
    // drop the held result once the sink takes it
    out_valid_nxt = out_valid_r && out_stall;
    out_rv_nxt    = out_rv_r;
    out_st_nxt    = out_st_r;
    out_cnt_nxt   = out_cnt_r;
    out_emp_nxt   = out_emp_r;

    unique case (state_r)
      ple_pkg::S_IDLE: begin
        if (in_valid) begin
          val_nxt    = val_in;
          rdval_nxt  = '0;
          status_nxt = ple_pkg::ST_OK;
          state_nxt  = ple_pkg::S_FIN;
          unique case (in_req_type)
            ple_pkg::REQ_PUSH_FRONT: begin
              if (not_full) begin
                // walk from the top of the list down to slot zero
                ptr_nxt   = cnt_r;
                end_nxt   = '0;
                state_nxt = ple_pkg::S_SH_UP;
              end else begin
                status_nxt = ple_pkg::ST_BOUND;
              end
            end
            ple_pkg::REQ_PUSH_BACK: begin
              if (not_full) begin
                ram_we    = 1'b1;
                ram_waddr = cnt_r[AW-1:0];
                ram_wdata = val_in;
                cnt_nxt   = cnt_r + CNT_W'(1);
              end else begin
                status_nxt = ple_pkg::ST_BOUND;
              end
            end
            ple_pkg::REQ_INSERT: begin
              if (not_full && (a_w != '0) && (a_w <= c_w + PW'(1))) begin
                ptr_nxt   = cnt_r;
                end_nxt   = a_dec[CNT_W-1:0];
                state_nxt = ple_pkg::S_SH_UP;
              end else begin
                status_nxt = ple_pkg::ST_BOUND;
              end
            end
            ple_pkg::REQ_ERASE: begin
              if (a_ok) begin
                ptr_nxt   = a_dec[CNT_W-1:0];
                end_nxt   = cnt_r - CNT_W'(1);
                state_nxt = ple_pkg::S_SH_DN;
              end else begin
                status_nxt = ple_pkg::ST_BOUND;
              end
            end
            ple_pkg::REQ_FILL: begin
              if ((a_w != '0) && (a_w <= cap_w)) begin
                ptr_nxt   = '0;
                end_nxt   = a_w[CNT_W-1:0];
                state_nxt = ple_pkg::S_FILL;
              end else begin
                status_nxt = ple_pkg::ST_BOUND;
              end
            end
            ple_pkg::REQ_SWAP: begin
              if (a_ok && b_ok) begin
                ram_raddr = a_dec[AW-1:0];
                ptr_nxt   = a_dec[CNT_W-1:0];
                end_nxt   = b_dec[CNT_W-1:0];
                state_nxt = ple_pkg::S_SW_A;
              end else begin
                status_nxt = ple_pkg::ST_BOUND;
              end
            end
            ple_pkg::REQ_READ: begin
              if (a_ok) begin
                ram_raddr = a_dec[AW-1:0];
                state_nxt = ple_pkg::S_RD_CAP;
              end else begin
                status_nxt = ple_pkg::ST_BOUND;
              end
            end
            ple_pkg::REQ_FRONT: begin
              if (cnt_r != '0) begin
                ram_raddr = '0;
                state_nxt = ple_pkg::S_RD_CAP;
              end else begin
                status_nxt = ple_pkg::ST_EMPTY;
              end
            end
            ple_pkg::REQ_BACK: begin
              if (cnt_r != '0) begin
                ram_raddr = cnt_r[AW-1:0] - AW'(1);
                state_nxt = ple_pkg::S_RD_CAP;
              end else begin
                status_nxt = ple_pkg::ST_EMPTY;
              end
            end
            ple_pkg::REQ_CLEAR: begin
              // slots past the count are never read before being written
              cnt_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end

      ple_pkg::S_SH_UP: begin
        if (ptr_r == end_r) begin
          ram_we    = 1'b1;
          ram_wdata = val_r;
          cnt_nxt   = cnt_r + CNT_W'(1);
          state_nxt = ple_pkg::S_FIN;
        end else begin
          ram_raddr = ptr_r[AW-1:0] - AW'(1);
          state_nxt = ple_pkg::S_UP_WR;
        end
      end

      ple_pkg::S_UP_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        ptr_nxt   = ptr_r - CNT_W'(1);
        state_nxt = ple_pkg::S_SH_UP;
      end

      ple_pkg::S_SH_DN: begin
        if (ptr_r == end_r) begin
          // zero the freed slot at the old top
          ram_we    = 1'b1;
          ram_wdata = '0;
          cnt_nxt   = cnt_r - CNT_W'(1);
          state_nxt = ple_pkg::S_FIN;
        end else begin
          ram_raddr = ptr_r[AW-1:0] + AW'(1);
          state_nxt = ple_pkg::S_DN_WR;
        end
      end

      ple_pkg::S_DN_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        ptr_nxt   = ptr_r + CNT_W'(1);
        state_nxt = ple_pkg::S_SH_DN;
      end

      ple_pkg::S_FILL: begin
        if (ptr_r == end_r) begin
          if (cnt_r < end_r) begin
            cnt_nxt = end_r;
          end
          state_nxt = ple_pkg::S_FIN;
        end else begin
          ram_we    = 1'b1;
          ram_wdata = val_r;
          ptr_nxt   = ptr_r + CNT_W'(1);
        end
      end

      ple_pkg::S_SW_A: begin
        // hold entry a, fetch entry b
        tmp_nxt   = ram_rdata;
        ram_raddr = end_r[AW-1:0];
        state_nxt = ple_pkg::S_SW_B;
      end

      ple_pkg::S_SW_B: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_r[AW-1:0];
        ram_wdata = ram_rdata;
        state_nxt = ple_pkg::S_SW_WB;
      end

      ple_pkg::S_SW_WB: begin
        ram_we    = 1'b1;
        ram_waddr = end_r[AW-1:0];
        ram_wdata = tmp_r;
        state_nxt = ple_pkg::S_FIN;
      end

      ple_pkg::S_RD_CAP: begin
        rdval_nxt = ram_rdata;
        state_nxt = ple_pkg::S_FIN;
      end

      ple_pkg::S_FIN: begin
        // advance into the output register once it is free or draining
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_rv_nxt    = rd_ext[31:0];
          out_st_nxt    = status_r;
          out_cnt_nxt   = cnt_r;
          out_emp_nxt   = (cnt_r == '0);
          state_nxt     = ple_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = ple_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_rv_r;
  assign out_status     = out_st_r;
  assign out_count      = out_cnt_r;
  assign out_is_empty   = out_emp_r;

`ifndef SYNTH
  a_cnt_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_emp_r == (out_cnt_r == '0)))
    else $error("empty flag disagrees with count");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_st_r == ple_pkg::ST_OK || out_st_r == ple_pkg::ST_BOUND ||
                     out_st_r == ple_pkg::ST_EMPTY))
    else $error("undefined status code");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ple_pkg::S_IDLE && state_r != ple_pkg::S_FILL) |=>
      (cnt_r == $past(cnt_r) || cnt_r == $past(cnt_r) + CNT_W'(1) ||
       cnt_r == $past(cnt_r) - CNT_W'(1)))
    else $error("count jumped during a shift walk");
`endif

endmodule

[rtl/core/ple_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ple_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
